// ----- design/kpc_pkg.sv -----
// Package for the key press classifier.
// Holds register indexes, reset values, widths and the shared struct types.
// No dependencies.
package kpc_pkg;

  localparam int KEYS_MAX          = 4;
  localparam int NUM_KEYS_DEF      = 4;
  localparam int COUNT_WIDTH_DEF   = 16;

  localparam int LEVEL_W           = 4;
  localparam int CODE_W            = 8;
  localparam int LONG_OFS          = 4;
  localparam int BOUND_W           = 16;
  localparam int PHASE_W           = 8;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_REPEAT = 2'd2;

  localparam logic [BOUND_W-1:0] SHORT_MIN_RST   = 16'd1;
  localparam logic [BOUND_W-1:0] SHORT_MAX_RST   = 16'd10;
  localparam logic [PHASE_W-1:0] LONG_REPEAT_RST = 8'd20;

  typedef struct packed {
    logic [BOUND_W-1:0] short_min;
    logic [BOUND_W-1:0] short_max;
    logic [PHASE_W-1:0] long_repeat;
  } kpc_cfg_t;

  typedef struct packed {
    logic short_hit;
    logic long_hit;
  } lane_res_t;

endpackage

// ----- design/kpc_ifs.sv -----
// Channel interfaces for the key press classifier: input, result and config.
// Depends on kpc_pkg.
interface kpc_in_if;
  import kpc_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] key_levels;
  modport source (output valid, output key_levels, input ready);
  modport sink (input valid, input key_levels, output ready);
endinterface

interface kpc_out_if;
  import kpc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] key_code;
  logic              any_event;
  modport source (output valid, output key_code, output any_event, input ready);
  modport sink (input valid, input key_code, input any_event, output ready);
endinterface

interface kpc_cfg_if;
  import kpc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/key_press_classifier.sv -----
// Top level of the key press classifier: config registers, key lanes, merge.
// Depends on kpc_pkg, kpc_ifs, kpc_lane and kpc_merge.
//
// Usage:
//   in_ch   one beat per sampling tick; key_levels bit i is key i, 1 released.
//   out_ch  exactly one result beat per input beat, in order: key_code holds
//           short-press bits in [3:0] and long-press bits in [7:4], any_event
//           is the OR of key_code.
//   cfg     register writes (index 0 short_min, 1 short_max, 2 long_repeat);
//           always ready, unknown indexes are dropped. Write only while idle.
// Latency: the result beat is valid the cycle after its input beat unless out_ch stalls.
// Throughput: one beat per cycle while in_ch is ready; every key lane updates
// its hold count and repeat phase in the accepting cycle.
// Reset: counters clear, registers take 1, 10 and 20, no result is pending.
// Stall: an output register and a skid register hold up to two results; in_ch
// ready drops only while the skid register is occupied.
module key_press_classifier #(
  parameter int NUM_KEYS    = kpc_pkg::NUM_KEYS_DEF,
  parameter int COUNT_WIDTH = kpc_pkg::COUNT_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  kpc_in_if.sink     in_ch,
  kpc_out_if.source  out_ch,
  kpc_cfg_if.sink    cfg
);
  import kpc_pkg::*;

  localparam logic [CODE_W-1:0] USED_MASK =
    CODE_W'(((1 << NUM_KEYS) - 1) | (((1 << NUM_KEYS) - 1) << LONG_OFS));

  kpc_cfg_t  cfg_regs;
  lane_res_t res [NUM_KEYS];
  logic      push;
  logic      room;
  logic      skid_full;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.short_min   <= SHORT_MIN_RST;
      cfg_regs.short_max   <= SHORT_MAX_RST;
      cfg_regs.long_repeat <= LONG_REPEAT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SHORT_MIN:   cfg_regs.short_min   <= cfg.data;
        REG_SHORT_MAX:   cfg_regs.short_max   <= cfg.data;
        REG_LONG_REPEAT: cfg_regs.long_repeat <= cfg.data[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = room;
  assign push        = in_ch.valid && room;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    kpc_lane #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .advance (push),
      .level   (in_ch.key_levels[k]),
      .cfg     (cfg_regs),
      .res     (res[k])
    );
  end

  kpc_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res       (res),
    .room      (room),
    .skid_full (skid_full),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_code  (out_ch.key_code)
  );

  assign out_ch.any_event = |out_ch.key_code;

  a_skid_implies_main: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_ch.valid)
    else $error("skid register holds a beat while the output register is empty");

  a_push_shows_result: assert property (@(posedge clk) disable iff (rst)
    push |=> out_ch.valid)
    else $error("accepted beat produced no result");

  a_unused_bits_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> ((out_ch.key_code & ~USED_MASK) == '0))
    else $error("key code bit set for a key lane that does not exist");

  a_stall_holds_skid: assert property (@(posedge clk) disable iff (rst)
    (skid_full && !out_ch.ready) |=> skid_full)
    else $error("skid beat dropped while the receiver stalls");

endmodule

// ----- design/kpc_lane.sv -----
// One key lane: saturating hold count, repeat phase and press decisions.
// Depends on kpc_pkg.
module kpc_lane #(
  parameter int COUNT_WIDTH = kpc_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               level,
  input  kpc_pkg::kpc_cfg_t  cfg,
  output kpc_pkg::lane_res_t res
);
  import kpc_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > BOUND_W) ? COUNT_WIDTH : BOUND_W;

  logic [COUNT_WIDTH-1:0] hold_count;
  logic [COUNT_WIDTH-1:0] hold_count_next;
  logic [PHASE_W-1:0]     repeat_phase;
  logic [PHASE_W-1:0]     repeat_phase_next;
  logic [PHASE_W-1:0]     phase_inc;
  logic [CMP_W-1:0]       hold_ext;
  logic [CMP_W-1:0]       min_ext;
  logic [CMP_W-1:0]       max_ext;

  always_comb begin
    hold_ext  = CMP_W'(hold_count);
    min_ext   = CMP_W'(cfg.short_min);
    max_ext   = CMP_W'(cfg.short_max);
    phase_inc = repeat_phase + PHASE_W'(1);
    res       = '0;
    if (level) begin
      res.short_hit     = (hold_ext > min_ext) && (hold_ext < max_ext);
      hold_count_next   = '0;
      repeat_phase_next = '0;
    end else begin
      hold_count_next   = (&hold_count) ? hold_count : hold_count + COUNT_WIDTH'(1);
      res.long_hit      = (phase_inc == cfg.long_repeat);
      repeat_phase_next = res.long_hit ? '0 : phase_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count   <= '0;
      repeat_phase <= '0;
    end else if (advance) begin
      hold_count   <= hold_count_next;
      repeat_phase <= repeat_phase_next;
    end
  end

endmodule

// ----- design/kpc_merge.sv -----
// Merge stage: packs lane hits into the key code and buffers result beats
// in an output register backed by a skid register. Depends on kpc_pkg.
module kpc_merge #(
  parameter int NUM_KEYS = kpc_pkg::NUM_KEYS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  kpc_pkg::lane_res_t        res [NUM_KEYS],
  output logic                      room,
  output logic                      skid_full,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [kpc_pkg::CODE_W-1:0] out_code
);
  import kpc_pkg::*;

  logic [CODE_W-1:0] code;
  logic [CODE_W-1:0] main_code;
  logic [CODE_W-1:0] skid_code;
  logic              main_v;
  logic              skid_v;
  logic              pop;

  always_comb begin
    code = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      code[k]            = res[k].short_hit;
      code[k + LONG_OFS] = res[k].long_hit;
    end
  end

  assign pop       = main_v && out_ready;
  assign room      = !skid_v;
  assign skid_full = skid_v;
  assign out_valid = main_v;
  assign out_code  = main_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (pop) begin
        skid_v <= 1'b0;
      end
    end else if (push) begin
      if (main_v && !pop) begin
        skid_v <= 1'b1;
      end else begin
        main_v <= 1'b1;
      end
    end else if (pop) begin
      main_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (pop) begin
        main_code <= skid_code;
      end
    end else if (push) begin
      if (main_v && !pop) begin
        skid_code <= code;
      end else begin
        main_code <= code;
      end
    end
  end

endmodule
